FILE: sv/ftoi_pkg.sv
`default_nettype none
package ftoi_pkg;
    localparam int MODE_W   = 2;
    localparam int DATA_W   = 64;
    localparam int SIG_W    = 53;
    localparam int EXP_W    = 11;

    // Mode codes
    localparam logic [1:0] MODE_F2I = 2'd0;
    localparam logic [1:0] MODE_F2L = 2'd1;
    localparam logic [1:0] MODE_D2I = 2'd2;
    localparam logic [1:0] MODE_D2L = 2'd3;

    localparam logic [63:0] INT_MAX_BITS  = 64'h0000_0000_7FFF_FFFF;
    localparam logic [63:0] INT_MIN_BITS  = 64'hFFFF_FFFF_8000_0000;
    localparam logic [63:0] LONG_MAX_BITS = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] LONG_MIN_BITS = 64'h8000_0000_0000_0000;

    // Decoded operand carried from the decode stage
    typedef struct packed {
        logic              neg;
        logic              zero;     // NaN, zero, |v| < 1
        logic              sat;      // infinity or magnitude at or over limit
        logic              is_long;
        logic [SIG_W-1:0]  sig;      // significand, left aligned at bit 52
        logic [5:0]        rshift;   // right shift applied to sig (e < 52)
        logic [5:0]        lshift;   // left shift (e >= 52)
    } dec_t;
endpackage
`default_nettype wire

FILE: sv/ftoi_decode.sv
`default_nettype none
// Stage 1: unpack the operand, classify it, and work out the shift.
module ftoi_decode (
    input  wire logic [1:0]  mode,
    input  wire logic [63:0] operand_bits,
    output ftoi_pkg::dec_t   dec
);
    logic             dbl;
    logic             neg;
    logic [10:0]      ebits;
    logic [10:0]      emax;
    logic [10:0]      bias;
    logic [51:0]      frac;
    logic [11:0]      e;
    logic [6:0]       lim;
    logic             below_one;

    always_comb
    begin
        dbl = mode[1];
        if (dbl)
        begin
            neg   = operand_bits[63];
            ebits = operand_bits[62:52];
            emax  = 11'h7FF;
            bias  = 11'd1023;
            frac  = operand_bits[51:0];
        end
        else
        begin
            neg   = operand_bits[31];
            ebits = {3'd0, operand_bits[30:23]};
            emax  = 11'h0FF;
            bias  = 11'd127;
            // single fraction moved up so both formats share 52-bit alignment
            frac  = {operand_bits[22:0], 29'd0};
        end
        lim       = mode[0] ? 7'd63 : 7'd31;
        below_one = (ebits < bias);
        e         = {1'b0, ebits} - {1'b0, bias};

        dec.neg     = neg;
        dec.is_long = mode[0];
        dec.sig     = {1'b1, frac};
        dec.zero    = ((ebits == emax) && (frac != 52'd0)) || below_one;
        dec.sat     = !dec.zero && ((ebits == emax) || (e >= {5'd0, lim}));
        dec.rshift  = (e < 12'd52) ? 6'(12'd52 - e) : 6'd0;
        dec.lshift  = (e >= 12'd52) ? 6'(e - 12'd52) : 6'd0;
    end
endmodule
`default_nettype wire

FILE: sv/ftoi_shift.sv
`default_nettype none
// Stage 2: align the significand into a magnitude.
module ftoi_shift (
    input  wire ftoi_pkg::dec_t dec,
    output logic [63:0]         mag
);
    logic [63:0] wide;

    always_comb
    begin
        wide = {11'd0, dec.sig};
        mag  = (wide >> dec.rshift) << dec.lshift;
    end
endmodule
`default_nettype wire

FILE: sv/float_to_int_saturating_convert.sv
`default_nettype none
// Java-style float/double to int/long converter. Fully pipelined in three
// register stages: decode, align, then negate/saturate into the output
// register. One item per cycle when no stall holds the pipe. Under a
// stall full stages hold and empty ones still fill, and ready is low only
// while all three stages hold items and the output side is not taking one.
module float_to_int_saturating_convert (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [1:0]  mode,
    input  wire logic [63:0] operand_bits,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic signed [63:0] result
);
    ftoi_pkg::dec_t dec_c;
    ftoi_pkg::dec_t s1_reg;
    logic           s1_v_reg;
    logic [63:0]    mag_c;
    logic [63:0]    s2_mag_reg;
    logic           s2_neg_reg, s2_zero_reg, s2_sat_reg, s2_long_reg;
    logic           s2_v_reg;
    logic [63:0]    s3_res_reg;
    logic           s3_v_reg;
    logic [63:0]    res_next;
    logic           en3, en2, en1;

    ftoi_decode u_dec (.mode(mode), .operand_bits(operand_bits), .dec(dec_c));
    ftoi_shift  u_sh  (.dec(s1_reg), .mag(mag_c));

    // Stall chain: a stage moves when the one after it can take its item
    assign en3      = !s3_v_reg || out_ready;
    assign en2      = !s2_v_reg || en3;
    assign en1      = !s1_v_reg || en2;
    assign in_ready = en1;

    // Final sign and saturation
    always_comb
    begin
        if (s2_zero_reg)
            res_next = 64'd0;
        else if (s2_sat_reg)
            res_next = s2_long_reg
                ? (s2_neg_reg ? ftoi_pkg::LONG_MIN_BITS : ftoi_pkg::LONG_MAX_BITS)
                : (s2_neg_reg ? ftoi_pkg::INT_MIN_BITS : ftoi_pkg::INT_MAX_BITS);
        else
            res_next = s2_neg_reg ? (64'd0 - s2_mag_reg) : s2_mag_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
            s3_v_reg <= 1'b0;
        end
        else
        begin
            if (en1) s1_v_reg <= in_valid;
            if (en2) s2_v_reg <= s1_v_reg;
            if (en3) s3_v_reg <= s2_v_reg;
        end
    end

    // Payload stages
    always_ff @(posedge clk)
    begin
        if (en1)
            s1_reg <= dec_c;
        if (en2)
        begin
            s2_mag_reg  <= mag_c;
            s2_neg_reg  <= s1_reg.neg;
            s2_zero_reg <= s1_reg.zero;
            s2_sat_reg  <= s1_reg.sat;
            s2_long_reg <= s1_reg.is_long;
        end
        if (en3)
            s3_res_reg <= res_next;
    end

    assign out_valid = s3_v_reg;
    assign result    = s3_res_reg;
endmodule
`default_nettype wire

FILE: sv/ftoi_checker.sv
`default_nettype none
// Port-level checks of the converter.
module ftoi_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_ready,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [63:0] result
);
    // A waiting result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(result))
        else $error("result dropped or changed under stall");

    // With the output side free the block always takes an item
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        out_ready |-> in_ready)
        else $error("input stalled with output free");

    // An item accepted into an empty, unstalled pipe reaches the output register
    a_lat: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready ##1 out_ready ##1 out_ready |=> out_valid)
        else $error("result missing after latency");

    // With no input and the output side free, the pipe drains empty
    a_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !in_valid && out_ready ##1 !in_valid && out_ready
        ##1 !in_valid && out_ready |=> !out_valid)
        else $error("result without item");
endmodule

bind float_to_int_saturating_convert ftoi_checker u_chk (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .result(result)
);
`default_nettype wire
